// ===== design/bep_pkg.sv =====
// Shared types and constants for the breakpoint envelope generator.
package bep_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 16;
  localparam int ID_W       = 32;
  localparam int DVD_W      = VAL_W + TIME_W;
  localparam int DCNT_W     = $clog2(DVD_W);

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DCNT_W-1:0] dcnt_t;

  typedef struct packed {
    logic [TIME_W-1:0]        ptime;
    logic signed [VAL_W-1:0]  value;
    logic [ID_W-1:0]          id;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_CMP,
    S_ADD_SHR,
    S_ADD_SHW,
    S_ADD_PUT,
    S_REM_RD,
    S_REM_CHK,
    S_SEEK_RD,
    S_SEEK_CMP,
    S_VAL,
    S_VAL_ONE,
    S_VAL_RD2,
    S_VAL_CAP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_ADV_RD,
    S_ADV_CMP,
    S_OUT
  } state_e;

endpackage

// ===== design/bep_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/breakpoint_envelope_generator.sv =====
// Breakpoint envelope generator: sorted control-point table in one RAM and a control FSM.
// One item at a time; in_ready_o is high only while the FSM is idle.
// Tick: steps through points in seek and advance, and takes an end value or interpolates
// (48-step serial divider) before the output transfer.
// Asynchronous active-low reset empties the table and invalidates the cursor.
module breakpoint_envelope_generator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [31:0]          point_id_i,
  input  logic [31:0]          point_time_i,
  input  logic signed [15:0]   point_value_i,
  input  logic                 playing_i,
  input  logic [31:0]          tick_start_i,
  input  logic [31:0]          tick_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   sample_value_o,
  output logic                 status_o
);

  bep_pkg::state_e state_q, state_d;
  bep_pkg::cnt_t   cnt_q, cnt_d, cur_q, cur_d, idx_q, idx_d, pos_q, pos_d;
  logic            cur_vld_q, cur_vld_d;
  logic [31:0]     last_end_q, last_end_d;
  logic [31:0]     id_q, id_d, ptime_q, ptime_d, start_q, start_d, end_q, end_d;
  logic signed [15:0] pval_q, pval_d, v1_q, v1_d, val_q, val_d;
  logic [31:0]     t1_q, t1_d, span_q, span_d, dd_q, dd_d;
  logic signed [16:0] diff_q, diff_d;
  logic            neg_q, neg_d, stat_q, stat_d;
  logic [bep_pkg::DVD_W-1:0] dvd_q, dvd_d;
  logic [31:0]     rem_q, rem_d;
  bep_pkg::dcnt_t  dcnt_q, dcnt_d;
  logic            ov_q, ov_d;
  logic signed [15:0] osv_q, osv_d;
  logic            ost_q, ost_d;

  logic            we;
  bep_pkg::idx_t   waddr, raddr;
  bep_pkg::entry_t wdata, rdata;

  logic [31:0]     span_c, ds_c;
  logic [16:0]     mag_c;
  logic [32:0]     rem_sh;
  logic            ge_c;
  logic signed [17:0] qx_c, res_c;
  bep_pkg::cnt_t   cnt_m1;

  bep_ram #(
    .WIDTH($bits(bep_pkg::entry_t)),
    .DEPTH(bep_pkg::MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o     = (state_q == bep_pkg::S_IDLE);
  assign out_valid_o    = ov_q;
  assign sample_value_o = osv_q;
  assign status_o       = ost_q;

  assign cnt_m1 = cnt_q - bep_pkg::cnt_t'(1);
  assign span_c = rdata.ptime - t1_q;
  assign ds_c   = start_q - t1_q;
  assign mag_c  = diff_q[16] ? 17'(-diff_q) : diff_q;
  assign rem_sh = {rem_q, dvd_q[bep_pkg::DVD_W-1]};
  assign ge_c   = (rem_sh >= {1'b0, span_q});
  assign qx_c   = $signed({2'b00, dvd_q[15:0]});
  assign res_c  = 18'(v1_q) + (neg_q ? -qx_c : qx_c);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; cur_d = cur_q; idx_d = idx_q; pos_d = pos_q;
    cur_vld_d = cur_vld_q; last_end_d = last_end_q;
    id_d = id_q; ptime_d = ptime_q; start_d = start_q; end_d = end_q;
    pval_d = pval_q; v1_d = v1_q; val_d = val_q; t1_d = t1_q; span_d = span_q; dd_d = dd_q;
    diff_d = diff_q; neg_d = neg_q; stat_d = stat_q; dvd_d = dvd_q; rem_d = rem_q;
    dcnt_d = dcnt_q; osv_d = osv_q; ost_d = ost_q;
    ov_d = ov_q && !out_ready_i;
    we = 1'b0; waddr = idx_q[bep_pkg::IDX_W-1:0]; raddr = idx_q[bep_pkg::IDX_W-1:0];
    wdata = rdata;

    unique case (state_q)
      bep_pkg::S_IDLE: begin
        if (in_valid_i) begin
          id_d = point_id_i; ptime_d = point_time_i;
          pval_d = point_value_i; start_d = tick_start_i; end_d = tick_end_i;
          val_d = '0; stat_d = 1'b0; idx_d = '0; pos_d = '0;
          state_d = bep_pkg::S_OUT;
          if (command_i == bep_pkg::CMD_ADD) begin
            cur_vld_d = 1'b0;
            if (cnt_q == bep_pkg::cnt_t'(bep_pkg::MAX_POINTS)) begin
              stat_d = 1'b1;
            end else begin
              state_d = bep_pkg::S_ADD_SCAN;
            end
          end else if (command_i == bep_pkg::CMD_REMOVE) begin
            cur_vld_d = 1'b0;
            state_d   = bep_pkg::S_REM_RD;
          end else if (command_i == bep_pkg::CMD_TICK) begin
            if (!playing_i) begin
              cur_vld_d = 1'b0;
            end else if (cnt_q == '0) begin
              last_end_d = tick_end_i;
            end else if (!cur_vld_q || tick_start_i != last_end_q) begin
              cur_d     = '0;
              cur_vld_d = 1'b1;
              state_d   = bep_pkg::S_SEEK_RD;
            end else begin
              if (cur_q > cnt_q) cur_d = cnt_q;
              state_d = bep_pkg::S_VAL;
            end
          end
        end
      end
      bep_pkg::S_ADD_SCAN: begin
        if (idx_q < cnt_q) begin
          state_d = bep_pkg::S_ADD_CMP;
        end else begin
          pos_d = idx_q; idx_d = cnt_q; state_d = bep_pkg::S_ADD_SHR;
        end
      end
      bep_pkg::S_ADD_CMP: begin
        if (rdata.ptime < ptime_q) begin
          idx_d = idx_q + bep_pkg::cnt_t'(1); state_d = bep_pkg::S_ADD_SCAN;
        end else begin
          pos_d = idx_q; idx_d = cnt_q; state_d = bep_pkg::S_ADD_SHR;
        end
      end
      bep_pkg::S_ADD_SHR: begin
        raddr = cnt_m1[bep_pkg::IDX_W-1:0];
        if (idx_q > pos_q) begin
          raddr   = bep_pkg::idx_t'(idx_q - bep_pkg::cnt_t'(1));
          state_d = bep_pkg::S_ADD_SHW;
        end else begin
          state_d = bep_pkg::S_ADD_PUT;
        end
      end
      bep_pkg::S_ADD_SHW: begin
        we = 1'b1;
        idx_d = idx_q - bep_pkg::cnt_t'(1); state_d = bep_pkg::S_ADD_SHR;
      end
      bep_pkg::S_ADD_PUT: begin
        we = 1'b1; waddr = pos_q[bep_pkg::IDX_W-1:0];
        wdata.ptime = ptime_q; wdata.value = pval_q; wdata.id = id_q;
        cnt_d = cnt_q + bep_pkg::cnt_t'(1); state_d = bep_pkg::S_OUT;
      end
      bep_pkg::S_REM_RD: begin
        if (idx_q < cnt_q) begin
          state_d = bep_pkg::S_REM_CHK;
        end else begin
          cnt_d = pos_q; state_d = bep_pkg::S_OUT;
        end
      end
      bep_pkg::S_REM_CHK: begin
        waddr = pos_q[bep_pkg::IDX_W-1:0];
        if (rdata.id != id_q) begin
          we = 1'b1; pos_d = pos_q + bep_pkg::cnt_t'(1);
        end
        idx_d = idx_q + bep_pkg::cnt_t'(1); state_d = bep_pkg::S_REM_RD;
      end
      bep_pkg::S_SEEK_RD: begin
        raddr = cur_q[bep_pkg::IDX_W-1:0];
        state_d = (cur_q < cnt_q) ? bep_pkg::S_SEEK_CMP : bep_pkg::S_VAL;
      end
      bep_pkg::S_SEEK_CMP: begin
        if (rdata.ptime < start_q) begin
          cur_d = cur_q + bep_pkg::cnt_t'(1); state_d = bep_pkg::S_SEEK_RD;
        end else begin
          state_d = bep_pkg::S_VAL;
        end
      end
      bep_pkg::S_VAL: begin
        if (cur_q == '0) begin
          raddr = '0; state_d = bep_pkg::S_VAL_ONE;
        end else if (cur_q >= cnt_q) begin
          raddr = cnt_m1[bep_pkg::IDX_W-1:0]; state_d = bep_pkg::S_VAL_ONE;
        end else begin
          raddr = bep_pkg::idx_t'(cur_q - bep_pkg::cnt_t'(1)); state_d = bep_pkg::S_VAL_RD2;
        end
      end
      bep_pkg::S_VAL_ONE: begin
        val_d = rdata.value; state_d = bep_pkg::S_ADV_RD;
      end
      bep_pkg::S_VAL_RD2: begin
        raddr = cur_q[bep_pkg::IDX_W-1:0];
        t1_d = rdata.ptime; v1_d = rdata.value; state_d = bep_pkg::S_VAL_CAP;
      end
      bep_pkg::S_VAL_CAP: begin
        span_d = span_c;
        diff_d = 17'(rdata.value) - 17'(v1_q);
        if (start_q < t1_q) dd_d = '0;
        else if (ds_c > span_c) dd_d = span_c;
        else dd_d = ds_c;
        if (span_c == '0) begin
          val_d = v1_q; state_d = bep_pkg::S_ADV_RD;
        end else begin
          state_d = bep_pkg::S_MUL;
        end
      end
      bep_pkg::S_MUL: begin
        dvd_d = mag_c[15:0] * dd_q;
        neg_d = diff_q[16]; rem_d = '0; dcnt_d = '0; state_d = bep_pkg::S_DIV;
      end
      bep_pkg::S_DIV: begin
        rem_d = ge_c ? rem_sh[31:0] - span_q : rem_sh[31:0];
        dvd_d = {dvd_q[bep_pkg::DVD_W-2:0], ge_c};
        dcnt_d = dcnt_q + bep_pkg::dcnt_t'(1);
        if (dcnt_q == bep_pkg::dcnt_t'(bep_pkg::DVD_W - 1)) state_d = bep_pkg::S_FIN;
      end
      bep_pkg::S_FIN: begin
        val_d = res_c[15:0]; state_d = bep_pkg::S_ADV_RD;
      end
      bep_pkg::S_ADV_RD: begin
        raddr = cur_q[bep_pkg::IDX_W-1:0];
        if (cur_q < cnt_q) begin
          state_d = bep_pkg::S_ADV_CMP;
        end else begin
          last_end_d = end_q; state_d = bep_pkg::S_OUT;
        end
      end
      bep_pkg::S_ADV_CMP: begin
        if (rdata.ptime < end_q) begin
          cur_d = cur_q + bep_pkg::cnt_t'(1); state_d = bep_pkg::S_ADV_RD;
        end else begin
          last_end_d = end_q; state_d = bep_pkg::S_OUT;
        end
      end
      bep_pkg::S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; osv_d = val_q; ost_d = stat_q; state_d = bep_pkg::S_IDLE;
        end
      end
      default: state_d = bep_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bep_pkg::S_IDLE;
      cnt_q <= '0; cur_q <= '0; cur_vld_q <= 1'b0; last_end_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; cur_q <= cur_d; cur_vld_q <= cur_vld_d; last_end_q <= last_end_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; pos_q <= pos_d; id_q <= id_d; ptime_q <= ptime_d;
    start_q <= start_d; end_q <= end_d; pval_q <= pval_d; v1_q <= v1_d; val_q <= val_d;
    t1_q <= t1_d; span_q <= span_d; dd_q <= dd_d; diff_q <= diff_d; neg_q <= neg_d;
    stat_q <= stat_d; dvd_q <= dvd_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    osv_q <= osv_d; ost_q <= ost_d;
  end

endmodule

// ===== design/bep_checker.sv =====
// Port-level checks for the breakpoint envelope generator, bound to the top level.
module bep_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] sample_value_o,
  input logic               status_o
);

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> sample_value_o == 16'sd0)
    else $error("dropped add carries a nonzero value");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_value_o) && $stable(status_o))
    else $error("result changed while stalled");

endmodule

bind breakpoint_envelope_generator bep_checker u_bep_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_value_o (sample_value_o),
  .status_o       (status_o)
);
